FILE: hw/rtl/ffsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and constants of the first-fit segment allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

    localparam int ADDR_BITS    = 16;
    localparam int LEN_BITS     = 16;
    localparam int MAX_SEG_DEF  = 16;
    localparam int OUT_CNT_BITS = 5;
    localparam logic [LEN_BITS-1:0] POOL_RESET = 16'd1000;

    // operations on the input channel
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BADFREE = 2'd3;

    // table operation broadcast to the cells
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_TAKE  = 2'd1;
    localparam logic [1:0] OP_SPLIT = 2'd2;
    localparam logic [1:0] OP_FREE  = 2'd3;

    typedef struct packed {
        logic [1:0]          op;
        logic                mprev;
        logic                mnext;
        logic [LEN_BITS-1:0] req;
    } cell_ctrl_t;

    typedef struct packed {
        logic                 valid;
        logic                 taken;
        logic                 sel;
        logic [ADDR_BITS-1:0] base;
        logic [LEN_BITS-1:0]  len;
        logic [ADDR_BITS-1:0] cut_base;
    } cell_view_t;

    localparam cell_view_t VIEW_NONE = '0;

endpackage
`default_nettype wire

FILE: hw/rtl/first_fit_segment_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_core
// First-fit pool allocator with coalescing on free, built as a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries requests: tuser selects allocate or free, tdata
//   holds the size and the address to release. Each transfer yields one
//   result transfer on the m_ channel: status in tuser, granted address and
//   segment count in tdata.
//   For a request, the cells compare their segments in the accept cycle,
//   then the first-hit chain picks one cell and the row splits, merges or
//   shifts in the next; the result is registered then.
//   No new request is taken until the last one's result has been built.
//   A cfg_ transfer sets the pool size and rebuilds the table as one free
//   segment.
//   Reset: pool size 1000, one free segment at address 0, no result pending.
//   Stall: a held result blocks new requests only after it has been built;
//   the block waits with s_tready low until the result is taken.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator_core
    import ffsa_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEG_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,      // pool_size
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,       // request_size, free_address
    input  wire logic [0:0]  s_tuser,       // func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,       // address, segments_in_use, pad
    output logic [1:0]       m_tuser        // status
);

    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    logic                busy_reg;
    logic                func_reg;
    logic [LEN_BITS-1:0] req_reg;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic                out_valid_reg;
    logic [1:0]          out_status_reg, status_next;
    logic [ADDR_BITS-1:0] out_addr_reg, addr_next;
    logic [OUT_CNT_BITS-1:0] out_cnt_reg;
    logic                accept, cfg_wr;

    cell_view_t          view [MAX_SEGMENTS];
    logic [MAX_SEGMENTS:0] hit_chain;
    logic [MAX_SEGMENTS-1:0] exact_v, nf_v, pf_v;
    cell_ctrl_t          ctrl;
    logic                exact_any, nf_any, pf_any, found;
    logic [ADDR_BITS-1:0] base_sel, cut_sel;

    assign cfg_ready = ~busy_reg;
    assign cfg_wr    = cfg_valid & cfg_ready;
    assign s_tready  = ~busy_reg & ~cfg_valid & (~out_valid_reg | m_tready);
    assign accept    = s_tvalid & s_tready;

    assign hit_chain[0] = 1'b0;
    assign found        = hit_chain[MAX_SEGMENTS];

    for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
        cell_view_t lv, r1v, r2v;
        if (i == 0) begin : g_l0
            assign lv = VIEW_NONE;
        end else begin : g_l
            assign lv = view[i-1];
        end
        if (i + 1 < MAX_SEGMENTS) begin : g_r1
            assign r1v = view[i+1];
        end else begin : g_r1e
            assign r1v = VIEW_NONE;
        end
        if (i + 2 < MAX_SEGMENTS) begin : g_r2
            assign r2v = view[i+2];
        end else begin : g_r2e
            assign r2v = VIEW_NONE;
        end
        ffsa_cell #(
            .IS_FIRST (i == 0)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .init       (cfg_wr),
            .init_len   (cfg_data),
            .load       (accept),
            .ld_func    (s_tuser[0]),
            .ld_req     (s_tdata[15:0]),
            .ld_where   (s_tdata[31:16]),
            .ctrl       (ctrl),
            .before_in  (hit_chain[i]),
            .before_out (hit_chain[i+1]),
            .left       (lv),
            .right1     (r1v),
            .right2     (r2v),
            .view       (view[i]),
            .exact_sel  (exact_v[i]),
            .next_free  (nf_v[i]),
            .prev_free  (pf_v[i])
        );
    end

    assign exact_any = |exact_v;
    assign nf_any    = |nf_v;
    assign pf_any    = |pf_v;

    always_comb begin
        base_sel = '0;
        cut_sel  = '0;
        for (int i = 0; i < MAX_SEGMENTS; i++) begin
            if (view[i].sel) begin
                base_sel = base_sel | view[i].base;
                cut_sel  = cut_sel | view[i].cut_base;
            end
        end
    end

    // decide the table operation while busy with a request
    always_comb begin
        ctrl.op     = OP_NONE;
        ctrl.mprev  = pf_any;
        ctrl.mnext  = nf_any;
        ctrl.req    = req_reg;
        status_next = ST_OK;
        addr_next   = '0;
        total_next  = total_reg;
        if (busy_reg) begin
            if (func_reg == FUNC_ALLOC) begin
                if (!found) begin
                    status_next = ST_NOFIT;
                end else if (exact_any) begin
                    ctrl.op   = OP_TAKE;
                    addr_next = base_sel;
                end else if (total_reg == CNT_W'(MAX_SEGMENTS)) begin
                    status_next = ST_FULL;
                end else begin
                    ctrl.op    = OP_SPLIT;
                    addr_next  = cut_sel;
                    total_next = total_reg + CNT_W'(1);
                end
            end else begin
                if (!found) begin
                    status_next = ST_BADFREE;
                end else begin
                    ctrl.op    = OP_FREE;
                    total_next = total_reg - CNT_W'(nf_any) - CNT_W'(pf_any);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            total_reg     <= CNT_W'(1);
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                total_reg <= CNT_W'(1);
            end else begin
                total_reg <= total_next;
            end
            if (accept) begin
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                busy_reg <= 1'b0;
            end
            if (busy_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg <= s_tuser[0];
            req_reg  <= s_tdata[15:0];
        end
        if (busy_reg) begin
            out_status_reg <= status_next;
            out_addr_reg   <= addr_next;
            out_cnt_reg    <= OUT_CNT_BITS'(total_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {3'b000, out_cnt_reg, out_addr_reg};

endmodule
`default_nettype wire

FILE: hw/rtl/ffsa_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffsa_cell
// One table entry: holds a segment, evaluates it against a request and
// shifts, splits or merges with its neighbours.
// ----------------------------------------------------------------------------
module ffsa_cell
    import ffsa_pkg::*;
#(
    parameter bit IS_FIRST = 1'b0
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 init,
    input  wire logic [LEN_BITS-1:0]  init_len,
    input  wire logic                 load,
    input  wire logic                 ld_func,
    input  wire logic [LEN_BITS-1:0]  ld_req,
    input  wire logic [ADDR_BITS-1:0] ld_where,
    input  wire cell_ctrl_t           ctrl,
    input  wire logic                 before_in,
    output logic                      before_out,
    input  wire cell_view_t           left,
    input  wire cell_view_t           right1,
    input  wire cell_view_t           right2,
    output cell_view_t                view,
    output logic                      exact_sel,
    output logic                      next_free,
    output logic                      prev_free
);

    logic                 valid_reg, valid_next;
    logic                 taken_reg, taken_next;
    logic [ADDR_BITS-1:0] base_reg, base_next;
    logic [LEN_BITS-1:0]  len_reg, len_next;
    logic                 flag_reg, exact_reg;
    logic [LEN_BITS-1:0]  rem_reg;
    logic                 sel, ge_k, gt_k, absorb, shift;
    logic [LEN_BITS-1:0]  add1, add2;
    cell_view_t           src;

    assign sel        = flag_reg & ~before_in;
    assign before_out = before_in | flag_reg;
    assign ge_k       = before_in | flag_reg;
    assign gt_k       = before_in;

    assign view.valid    = valid_reg;
    assign view.taken    = taken_reg;
    assign view.sel      = sel;
    assign view.base     = base_reg;
    assign view.len      = len_reg;
    assign view.cut_base = base_reg + ADDR_BITS'(rem_reg);

    assign exact_sel = sel & exact_reg;
    assign next_free = sel & right1.valid & ~right1.taken;
    assign prev_free = sel & left.valid & ~left.taken;

    assign absorb = ctrl.mprev ? right1.sel : sel;
    assign shift  = (ctrl.mprev | ctrl.mnext) & (ctrl.mprev ? ge_k : gt_k);
    assign add1   = (ctrl.mprev | ctrl.mnext) ? right1.len : '0;
    assign add2   = (ctrl.mprev & ctrl.mnext) ? right2.len : '0;
    assign src    = (ctrl.mprev & ctrl.mnext) ? right2 : right1;

    always_comb begin
        valid_next = valid_reg;
        taken_next = taken_reg;
        base_next  = base_reg;
        len_next   = len_reg;
        case (ctrl.op)
            OP_TAKE: begin
                if (sel) begin
                    taken_next = 1'b1;
                end
            end
            OP_SPLIT: begin
                if (sel) begin
                    len_next = rem_reg;
                end else if (left.sel) begin
                    valid_next = 1'b1;
                    taken_next = 1'b1;
                    base_next  = left.cut_base;
                    len_next   = ctrl.req;
                end else if (gt_k) begin
                    valid_next = left.valid;
                    taken_next = left.taken;
                    base_next  = left.base;
                    len_next   = left.len;
                end
            end
            OP_FREE: begin
                if (absorb) begin
                    len_next = len_reg + add1 + add2;
                    if (!ctrl.mprev) begin
                        taken_next = 1'b0;
                    end
                end else if (shift) begin
                    valid_next = src.valid;
                    taken_next = src.taken;
                    base_next  = src.base;
                    len_next   = src.len;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= IS_FIRST;
            taken_reg <= 1'b0;
            base_reg  <= '0;
            len_reg   <= IS_FIRST ? POOL_RESET : '0;
            flag_reg  <= 1'b0;
        end else if (init) begin
            valid_reg <= IS_FIRST;
            taken_reg <= 1'b0;
            base_reg  <= '0;
            len_reg   <= IS_FIRST ? init_len : '0;
            flag_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            taken_reg <= taken_next;
            base_reg  <= base_next;
            len_reg   <= len_next;
            if (load) begin
                if (ld_func == FUNC_FREE) begin
                    flag_reg <= valid_reg & taken_reg & (base_reg == ld_where);
                end else begin
                    flag_reg <= valid_reg & ~taken_reg & (ld_req != '0)
                                & (len_reg >= ld_req);
                end
            end
        end
    end

    // evaluation results for the request being accepted
    always_ff @(posedge aclk) begin
        if (load) begin
            exact_reg <= (len_reg == ld_req);
            rem_reg   <= len_reg - ld_req;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/ffsa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffsa_checker
// Port-level checks of the allocator core, bound to its top level.
// ----------------------------------------------------------------------------
module ffsa_checker
    import ffsa_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // one request at a time
    a_one_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("result missing two cycles after request");

    a_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> m_tdata[15:0] == 16'd0)
        else $error("address not zero on failed request");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[20:16] != 5'd0)
        else $error("segment count zero");

endmodule

bind first_fit_segment_allocator_core ffsa_checker u_ffsa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
